>>> rtl/citr_pkg.sv
`default_nettype none

package citr_pkg;

  localparam int unsigned REGS_PER_CCE  = 6;
  localparam int unsigned MAX_REG_COUNT = 810;

  // floor(x/3) == (x*683) >> 11 for x < 2048
  localparam logic [19:0] RECIP3       = 20'd683;
  localparam int unsigned RECIP3_SHIFT = 11;

  // restoring divider: one quotient bit per step
  localparam int unsigned DIV_W     = 10;
  localparam logic [3:0]  DIV_STEPS = 4'(DIV_W);

  typedef enum logic [2:0] {
    CFG_INTERLEAVE_ON    = 3'd0,
    CFG_BUNDLE_SIZE      = 3'd1,
    CFG_INTERLEAVER_ROWS = 3'd2,
    CFG_SHIFT_INDEX      = 3'd3,
    CFG_REG_COUNT        = 3'd4,
    CFG_SYMBOL_COUNT     = 3'd5
  } citr_cfg_idx_e;

  typedef enum logic [1:0] {
    DRV_BUNDLES,
    DRV_COLS,
    DRV_SHIFT,
    DRV_DONE
  } citr_drv_state_e;

  // values derived from the configuration registers
  typedef struct packed {
    logic [7:0] cols;        // reg_count / (L*R)
    logic [8:0] bundles;     // reg_count / L
    logic [8:0] shift_mod;   // shift_index mod bundles
    logic       cols_exact;  // reg_count is a multiple of L*R
  } citr_derived_t;

endpackage

`default_nettype wire

>>> rtl/citr_derive.sv
`default_nettype none

// Works out the interleaver sizes after every configuration write with one
// shared restoring divider: bundles, then columns, then the reduced shift.
module citr_derive import citr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic [9:0]    reg_count_i,
  input  logic [2:0]    bundle_size_i,
  input  logic [2:0]    interleaver_rows_i,
  input  logic [8:0]    shift_index_i,
  output citr_derived_t derived_o,
  output logic          busy_o
);

  citr_drv_state_e st_q, st_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [9:0]      rem_q, rem_d;
  logic [9:0]      dq_q, dq_d;
  logic [8:0]      bundles_q, bundles_d;
  logic [8:0]      shift_mod_q, shift_mod_d;
  logic [7:0]      cols_q, cols_d;
  logic            exact_q, exact_d;

  logic [5:0]  lr_prod;
  logic [9:0]  divisor;
  logic [9:0]  dividend;
  logic [10:0] trial;
  logic        qbit;
  logic [9:0]  rem_step;
  logic [9:0]  dq_step;
  logic        last_step;

  assign lr_prod   = {3'b000, bundle_size_i} * {3'b000, interleaver_rows_i};
  assign last_step = (st_q != DRV_DONE) && (cnt_q == DIV_STEPS);

  // next state
  always_comb begin
    st_d = st_q;
    if (restart_i) begin
      st_d = DRV_BUNDLES;
    end else begin
      case (st_q)
        DRV_BUNDLES: if (last_step) st_d = DRV_COLS;
        DRV_COLS:    if (last_step) st_d = DRV_SHIFT;
        DRV_SHIFT:   if (last_step) st_d = DRV_DONE;
        DRV_DONE:    st_d = DRV_DONE;
        default:     st_d = DRV_BUNDLES;
      endcase
    end
  end

  // outputs: operand selection per state
  always_comb begin
    busy_o = (st_q != DRV_DONE);
    case (st_q)
      DRV_BUNDLES: begin
        divisor  = {7'b0, bundle_size_i};
        dividend = reg_count_i;
      end
      DRV_COLS: begin
        divisor  = {4'b0, lr_prod};
        dividend = reg_count_i;
      end
      DRV_SHIFT: begin
        divisor  = {1'b0, bundles_q};
        dividend = {1'b0, shift_index_i};
      end
      default: begin
        divisor  = '0;
        dividend = '0;
      end
    endcase
  end

  assign trial    = {rem_q, dq_q[9]};
  assign qbit     = (trial >= {1'b0, divisor});
  assign rem_step = qbit ? 10'(trial - {1'b0, divisor}) : trial[9:0];
  assign dq_step  = {dq_q[8:0], qbit};

  // divider datapath; count 0 loads operands, counts 1..DIV_STEPS shift
  always_comb begin
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    bundles_d   = bundles_q;
    cols_d      = cols_q;
    exact_d     = exact_q;
    shift_mod_d = shift_mod_q;
    if (restart_i) begin
      cnt_d = '0;
    end else if (st_q != DRV_DONE) begin
      if (cnt_q == '0) begin
        rem_d = '0;
        dq_d  = dividend;
        cnt_d = 4'd1;
      end else begin
        rem_d = rem_step;
        dq_d  = dq_step;
        if (last_step) begin
          cnt_d = '0;
          case (st_q)
            DRV_BUNDLES: bundles_d = dq_step[8:0];
            DRV_COLS: begin
              cols_d  = dq_step[7:0];
              exact_d = (rem_step == '0);
            end
            DRV_SHIFT:   shift_mod_d = rem_step[8:0];
            default:     ;
          endcase
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= DRV_BUNDLES;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    dq_q        <= dq_d;
    bundles_q   <= bundles_d;
    cols_q      <= cols_d;
    exact_q     <= exact_d;
    shift_mod_q <= shift_mod_d;
  end

  assign derived_o.cols       = cols_q;
  assign derived_o.bundles    = bundles_q;
  assign derived_o.shift_mod  = shift_mod_q;
  assign derived_o.cols_exact = exact_q;

endmodule

`default_nettype wire

>>> rtl/cce_to_reg_interleave_map_top.sv
`default_nettype none

// CCE-to-REG mapper for a PDCCH control resource set.
// Request channel: cce_index_i is taken at a clock edge with start_i high and
// busy_o low. Each request yields six REG results on consecutive cycles, each
// shown for one cycle under result_strobe_o, last_reg_o on the sixth. A bad
// configuration or a CCE outside the set gives one result with config_error_o
// and last_reg_o set and the index fields zero.
// Path: an accepted request passes the sequencer register, pipeline registers
// p2 to p7 and the output register before its first result is on the ports;
// later results follow one per cycle. The sequencer issues one REG per cycle
// into an 8-stage pipeline and takes a new request in the cycle the previous
// one issues its last REG, so error requests can be taken one per cycle.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// the user must write only while idle, the block does not enforce it. After
// each write, and after reset, busy_o stays high while a shared divider
// derives bundle count, column count and reduced shift.
// Reset clears the configuration to its defaults and empties the pipeline.
// The receiver cannot stall: results leave on a fixed schedule.
module cce_to_reg_interleave_map_top import citr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] cce_index_i,
  output logic       result_strobe_o,
  output logic [9:0] reg_index_o,
  output logic [1:0] symbol_index_o,
  output logic [8:0] rb_index_o,
  output logic       config_error_o,
  output logic       last_reg_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  // configuration registers
  logic       intl_q;
  logic [2:0] bsize_q;
  logic [2:0] rows_q;
  logic [8:0] shift_q;
  logic [9:0] rcount_q;
  logic [1:0] symc_q;

  logic          cfg_write;
  citr_derived_t drv;
  logic          drv_busy;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intl_q   <= 1'b0;
      bsize_q  <= 3'd6;
      rows_q   <= 3'd2;
      shift_q  <= '0;
      rcount_q <= 10'd6;
      symc_q   <= 2'd1;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_INTERLEAVE_ON:    intl_q   <= cfg_data_i[0];
        CFG_BUNDLE_SIZE:      bsize_q  <= cfg_data_i[2:0];
        CFG_INTERLEAVER_ROWS: rows_q   <= cfg_data_i[2:0];
        CFG_SHIFT_INDEX:      shift_q  <= cfg_data_i[8:0];
        CFG_REG_COUNT:        rcount_q <= cfg_data_i;
        CFG_SYMBOL_COUNT:     symc_q   <= cfg_data_i[1:0];
        default:              ;
      endcase
    end
  end

  citr_derive u_derive (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .restart_i          (cfg_write),
    .reg_count_i        (rcount_q),
    .bundle_size_i      (bsize_q),
    .interleaver_rows_i (rows_q),
    .shift_index_i      (shift_q),
    .derived_o          (drv),
    .busy_o             (drv_busy)
  );

  // ---------------- request check and sequencer ----------------
  logic        accept;
  logic [8:0]  cce_p1;
  logic [10:0] cce_span;
  logic        bsize_ok, rows_ok, err_now;
  logic [9:0]  first_b;

  logic       sq_valid_q, sq_valid_d;
  logic       sq_err_q, sq_err_d;
  logic [9:0] sq_b_q, sq_b_d;
  logic [2:0] sq_k_q, sq_k_d;
  logic [2:0] sq_n_q, sq_n_d;
  logic       sq_final;

  assign sq_final = sq_err_q | (sq_n_q == 3'(REGS_PER_CCE - 1));
  assign busy_o   = drv_busy | (sq_valid_q & ~sq_final);
  assign accept   = start_i & ~busy_o;

  assign cce_p1   = {1'b0, cce_index_i} + 9'd1;
  assign cce_span = {cce_p1, 2'b00} + {1'b0, cce_p1, 1'b0};
  assign bsize_ok = bsize_q inside {3'd2, 3'd3, 3'd6};
  assign rows_ok  = rows_q inside {3'd2, 3'd3, 3'd6};

  always_comb begin
    err_now = (symc_q == 2'd0) || (rcount_q > 10'(MAX_REG_COUNT)) ||
              (cce_span > {1'b0, rcount_q});
    if (intl_q) begin
      err_now = err_now || !bsize_ok || !rows_ok || !drv.cols_exact;
    end else begin
      err_now = err_now || (bsize_q != 3'(REGS_PER_CCE));
    end
  end

  // first bundle = cce * (6 / L)
  always_comb begin
    case (bsize_q)
      3'd2:    first_b = {2'b00, cce_index_i} + {1'b0, cce_index_i, 1'b0};
      3'd3:    first_b = {1'b0, cce_index_i, 1'b0};
      default: first_b = {2'b00, cce_index_i};
    endcase
  end

  always_comb begin
    sq_valid_d = sq_valid_q;
    sq_err_d   = sq_err_q;
    sq_b_d     = sq_b_q;
    sq_k_d     = sq_k_q;
    sq_n_d     = sq_n_q;
    if (accept) begin
      sq_valid_d = 1'b1;
      sq_err_d   = err_now;
      sq_b_d     = first_b;
      sq_k_d     = '0;
      sq_n_d     = '0;
    end else if (sq_valid_q) begin
      if (sq_final) begin
        sq_valid_d = 1'b0;
      end else begin
        sq_n_d = sq_n_q + 3'd1;
        if (sq_k_q == bsize_q - 3'd1) begin
          sq_k_d = '0;
          sq_b_d = sq_b_q + 10'd1;
        end else begin
          sq_k_d = sq_k_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else begin
      sq_valid_q <= sq_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_err_q <= sq_err_d;
    sq_b_q   <= sq_b_d;
    sq_k_q   <= sq_k_d;
    sq_n_q   <= sq_n_d;
  end

  // ---------------- REG pipeline ----------------
  // stage 2: bundle / R
  logic [9:0]  s2_div_in;
  logic [19:0] s2_prod;
  logic [8:0]  s2_q;

  assign s2_div_in = (rows_q == 3'd6) ? {1'b0, sq_b_q[9:1]} : sq_b_q;
  assign s2_prod   = {10'b0, s2_div_in} * RECIP3;

  always_comb begin
    case (rows_q)
      3'd3, 3'd6: s2_q = s2_prod[RECIP3_SHIFT +: 9];
      default:    s2_q = sq_b_q[9:1];
    endcase
  end

  logic       p2_valid_q, p2_err_q, p2_last_q;
  logic [2:0] p2_k_q;
  logic [9:0] p2_b_q;
  logic [8:0] p2_q_q;

  // stage 3: bundle mod R
  logic [11:0] s3_qr;
  logic [2:0]  s3_r;

  always_comb begin
    case (rows_q)
      3'd3:    s3_qr = {3'b000, p2_q_q} + {2'b00, p2_q_q, 1'b0};
      3'd6:    s3_qr = {2'b00, p2_q_q, 1'b0} + {1'b0, p2_q_q, 2'b00};
      default: s3_qr = {2'b00, p2_q_q, 1'b0};
    endcase
  end

  assign s3_r = 3'({2'b00, p2_b_q} - s3_qr);

  logic       p3_valid_q, p3_err_q, p3_last_q;
  logic [2:0] p3_k_q;
  logic [9:0] p3_b_q;
  logic [8:0] p3_q_q;
  logic [2:0] p3_r_q;

  // stage 4: r*C + b/R + shift
  logic [10:0] s4_rc;
  logic [10:0] s4_t;

  assign s4_rc = {8'b0, p3_r_q} * {3'b000, drv.cols};
  assign s4_t  = s4_rc + {2'b00, p3_q_q} + {2'b00, drv.shift_mod};

  logic        p4_valid_q, p4_err_q, p4_last_q;
  logic [2:0]  p4_k_q;
  logic [9:0]  p4_b_q;
  logic [10:0] p4_t_q;

  // stage 5: wrap into the bundle range (sum stays below twice the count)
  logic [9:0] s5_idx;

  always_comb begin
    if (!intl_q) begin
      s5_idx = p4_b_q;
    end else if (p4_t_q >= {2'b00, drv.bundles}) begin
      s5_idx = 10'(p4_t_q - {2'b00, drv.bundles});
    end else begin
      s5_idx = p4_t_q[9:0];
    end
  end

  logic       p5_valid_q, p5_err_q, p5_last_q;
  logic [2:0] p5_k_q;
  logic [9:0] p5_idx_q;

  // stage 6: REG = bundle * L + k
  logic [12:0] s6_idx_x;
  logic [12:0] s6_scaled;
  logic [12:0] s6_reg;

  assign s6_idx_x = {3'b000, p5_idx_q};

  always_comb begin
    case (bsize_q)
      3'd2:    s6_scaled = s6_idx_x << 1;
      3'd3:    s6_scaled = s6_idx_x + (s6_idx_x << 1);
      default: s6_scaled = (s6_idx_x << 2) + (s6_idx_x << 1);
    endcase
  end

  assign s6_reg = s6_scaled + {10'b0, p5_k_q};

  logic       p6_valid_q, p6_err_q, p6_last_q;
  logic [9:0] p6_reg_q;

  // stage 7: REG / symbol count
  logic [19:0] s7_prod;
  logic [9:0]  s7_rq;

  assign s7_prod = {10'b0, p6_reg_q} * RECIP3;

  always_comb begin
    case (symc_q)
      2'd1:    s7_rq = p6_reg_q;
      2'd2:    s7_rq = {1'b0, p6_reg_q[9:1]};
      default: s7_rq = {1'b0, s7_prod[RECIP3_SHIFT +: 9]};
    endcase
  end

  logic       p7_valid_q, p7_err_q, p7_last_q;
  logic [9:0] p7_reg_q;
  logic [9:0] p7_rq_q;

  // stage 8: symbol = REG - rb * symbol count, output register
  logic [11:0] s8_back;
  logic [1:0]  s8_sym;

  always_comb begin
    case (symc_q)
      2'd1:    s8_back = {2'b00, p7_rq_q};
      2'd2:    s8_back = {1'b0, p7_rq_q, 1'b0};
      default: s8_back = {2'b00, p7_rq_q} + {1'b0, p7_rq_q, 1'b0};
    endcase
  end

  assign s8_sym = 2'({2'b00, p7_reg_q} - s8_back);

  logic       out_valid_q;
  logic [9:0] out_reg_q;
  logic [1:0] out_sym_q;
  logic [8:0] out_rb_q;
  logic       out_err_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      p4_valid_q  <= 1'b0;
      p5_valid_q  <= 1'b0;
      p6_valid_q  <= 1'b0;
      p7_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p2_valid_q  <= sq_valid_q;
      p3_valid_q  <= p2_valid_q;
      p4_valid_q  <= p3_valid_q;
      p5_valid_q  <= p4_valid_q;
      p6_valid_q  <= p5_valid_q;
      p7_valid_q  <= p6_valid_q;
      out_valid_q <= p7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_err_q   <= sq_err_q;
    p2_last_q  <= sq_final;
    p2_k_q     <= sq_k_q;
    p2_b_q     <= sq_b_q;
    p2_q_q     <= s2_q;

    p3_err_q   <= p2_err_q;
    p3_last_q  <= p2_last_q;
    p3_k_q     <= p2_k_q;
    p3_b_q     <= p2_b_q;
    p3_q_q     <= p2_q_q;
    p3_r_q     <= s3_r;

    p4_err_q   <= p3_err_q;
    p4_last_q  <= p3_last_q;
    p4_k_q     <= p3_k_q;
    p4_b_q     <= p3_b_q;
    p4_t_q     <= s4_t;

    p5_err_q   <= p4_err_q;
    p5_last_q  <= p4_last_q;
    p5_k_q     <= p4_k_q;
    p5_idx_q   <= s5_idx;

    p6_err_q   <= p5_err_q;
    p6_last_q  <= p5_last_q;
    p6_reg_q   <= s6_reg[9:0];

    p7_err_q   <= p6_err_q;
    p7_last_q  <= p6_last_q;
    p7_reg_q   <= p6_reg_q;
    p7_rq_q    <= s7_rq;

    out_err_q  <= p7_err_q;
    out_last_q <= p7_last_q;
    out_reg_q  <= p7_err_q ? '0 : p7_reg_q;
    out_sym_q  <= p7_err_q ? '0 : s8_sym;
    out_rb_q   <= p7_err_q ? '0 : p7_rq_q[8:0];
  end

  assign result_strobe_o = out_valid_q;
  assign reg_index_o     = out_reg_q;
  assign symbol_index_o  = out_sym_q;
  assign rb_index_o      = out_rb_q;
  assign config_error_o  = out_err_q;
  assign last_reg_o      = out_last_q;

endmodule

`default_nettype wire

>>> rtl/citr_checker.sv
`default_nettype none

module citr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_strobe_o,
  input logic [9:0] reg_index_o,
  input logic [1:0] symbol_index_o,
  input logic [8:0] rb_index_o,
  input logic       config_error_o,
  input logic       last_reg_o
);

  // every accepted request shows its first result after a fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##8 result_strobe_o)
    else $error("no result 8 cycles after an accepted request");

  // results of one CCE come out back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_reg_o |=> result_strobe_o)
    else $error("gap inside a CCE's result burst");

  // a good CCE ends a burst of six
  a_six: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_reg_o && !config_error_o |->
      $past(result_strobe_o, 5) && !$past(last_reg_o, 1))
    else $error("valid CCE did not give six results");

  // an error result is also the last one and has zeroed indices
  a_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && config_error_o |->
      last_reg_o && reg_index_o == 10'd0 && symbol_index_o == 2'd0 &&
      rb_index_o == 9'd0)
    else $error("malformed error result");

endmodule

bind cce_to_reg_interleave_map_top citr_checker u_citr_checker (.*);

`default_nettype wire

>>> tb/sv/cce_to_reg_interleave_map_top_test.sv
`default_nettype none

module cce_to_reg_interleave_map_top_test;
  import citr_pkg::*;

  localparam int unsigned STALL_LIMIT = 400;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [9:0] reg_index;
    logic [1:0] symbol_index;
    logic [8:0] rb_index;
    logic       config_error;
    logic       last_reg;
  } reg_result_t;

  typedef struct {
    logic       interleave_on;
    logic [2:0] bundle_size;
    logic [2:0] rows;
    logic [8:0] shift;
    logic [9:0] reg_count;
    logic [1:0] sym_count;
  } coreset_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic [7:0] cce_index_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [9:0] cfg_data_i = '0;
  logic       busy_o;
  logic       result_strobe_o;
  logic [9:0] reg_index_o;
  logic [1:0] symbol_index_o;
  logic [8:0] rb_index_o;
  logic       config_error_o;
  logic       last_reg_o;
  logic       cfg_ready_o;

  coreset_t      coreset;
  reg_result_t   expected_regs[$];
  int unsigned   mismatches = 0;
  int unsigned   stall_cycles = 0;

  cce_to_reg_interleave_map_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cce_index_i    (cce_index_i),
    .result_strobe_o(result_strobe_o),
    .reg_index_o    (reg_index_o),
    .symbol_index_o (symbol_index_o),
    .rb_index_o     (rb_index_o),
    .config_error_o (config_error_o),
    .last_reg_o     (last_reg_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit legal_size(input int unsigned v);
    return v == 2 || v == 3 || v == 6;
  endfunction

  // Expected REG list of one CCE under the current coreset
  function automatic void predict_cce_regs(input logic [7:0] cce);
    int unsigned len, rows, regs, syms, cols, bundles, per_cce, first, idx, regn, n;
    bit bad;
    reg_result_t r;
    len  = coreset.bundle_size;
    rows = coreset.rows;
    regs = coreset.reg_count;
    syms = coreset.sym_count;
    cols = 0;
    bad  = syms == 0 || regs > MAX_REG_COUNT || REGS_PER_CCE * (cce + 1) > regs;
    if (!bad) begin
      if (coreset.interleave_on) begin
        if (!legal_size(len) || !legal_size(rows)) bad = 1'b1;
        else if (regs % (len * rows) != 0) bad = 1'b1;
        else cols = regs / (len * rows);
      end else if (len != REGS_PER_CCE) begin
        bad = 1'b1;
      end
    end
    if (bad) begin
      r = '0;
      r.config_error = 1'b1;
      r.last_reg = 1'b1;
      expected_regs.push_back(r);
      return;
    end
    bundles = regs / len;
    per_cce = REGS_PER_CCE / len;
    first = cce * per_cce;
    n = 0;
    for (int unsigned b = first; b < first + per_cce; b++) begin
      if (coreset.interleave_on)
        idx = ((b % rows) * cols + b / rows + coreset.shift) % bundles;
      else
        idx = b;
      for (int unsigned k = 0; k < len; k++) begin
        regn = idx * len + k;
        r.reg_index    = regn[9:0];
        r.symbol_index = 2'(regn % syms);
        r.rb_index     = 9'(regn / syms);
        r.config_error = 1'b0;
        r.last_reg     = (n == REGS_PER_CCE - 1);
        expected_regs.push_back(r);
        n++;
      end
    end
  endfunction

  // start_i is left high so back-to-back requests need no extra edge
  task automatic request_cce(input logic [7:0] cce);
    start_i <= 1'b1;
    cce_index_i <= cce;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_cce_regs(cce);
  endtask

  task automatic pause_requests(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input citr_cfg_idx_e idx, input logic [9:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_INTERLEAVE_ON:    coreset.interleave_on = data[0];
      CFG_BUNDLE_SIZE:      coreset.bundle_size = data[2:0];
      CFG_INTERLEAVER_ROWS: coreset.rows = data[2:0];
      CFG_SHIFT_INDEX:      coreset.shift = data[8:0];
      CFG_REG_COUNT:        coreset.reg_count = data[9:0];
      CFG_SYMBOL_COUNT:     coreset.sym_count = data[1:0];
      default: ;
    endcase
  endtask

  // drain the pipeline, then rewrite every register
  task automatic apply_coreset(input logic [9:0] il, bsz, rows, shift, regs, syms);
    start_i <= 1'b0;
    while (expected_regs.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    write_reg(CFG_INTERLEAVE_ON, il);
    write_reg(CFG_BUNDLE_SIZE, bsz);
    write_reg(CFG_INTERLEAVER_ROWS, rows);
    write_reg(CFG_SHIFT_INDEX, shift);
    write_reg(CFG_REG_COUNT, regs);
    write_reg(CFG_SYMBOL_COUNT, syms);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [9:0] pick_size();
    case ($urandom_range(0, 2))
      0: return 10'd2;
      1: return 10'd3;
      default: return 10'd6;
    endcase
  endfunction

  task automatic roll_coreset(input bit sane);
    logic [9:0] il, bsz, rows, regs;
    int unsigned prod;
    if (!sane) begin
      apply_coreset(10'($urandom), 10'($urandom), 10'($urandom),
                    10'($urandom), 10'($urandom), 10'($urandom));
      return;
    end
    il = 10'($urandom_range(0, 1));
    rows = pick_size();
    if (il[0]) begin
      bsz = pick_size();
      prod = bsz * rows;
      regs = 10'(prod * $urandom_range((6 + prod - 1) / prod, 810 / prod));
    end else begin
      bsz = 10'd6;
      regs = 10'(6 * $urandom_range(1, 135));
    end
    apply_coreset(il, bsz, rows, 10'($urandom_range(0, 274)), regs,
                  10'($urandom_range(1, 3)));
  endtask

  task automatic test_reset_defaults();
    request_cce(8'd0);
    request_cce(8'd1);
    request_cce(8'd255);
  endtask

  task automatic test_identity_map();
    apply_coreset(0, 6, 2, 0, 810, 3);
    request_cce(8'd0);
    request_cce(8'd134);
    request_cce(8'd135);
    apply_coreset(0, 6, 2, 0, 810, 1);
    request_cce(8'd134);
    apply_coreset(0, 6, 2, 0, 810, 2);
    request_cce(8'd85);
  endtask

  task automatic test_interleaved_map();
    apply_coreset(1, 2, 3, 0, 810, 3);
    request_cce(8'd0);
    request_cce(8'd134);
    apply_coreset(1, 3, 6, 274, 810, 2);
    request_cce(8'd0);
    request_cce(8'd134);
    apply_coreset(1, 6, 6, 511, 792, 3);
    request_cce(8'd131);
    request_cce(8'd0);
    apply_coreset(1, 6, 2, 0, 12, 1);
    request_cce(8'd0);
    request_cce(8'd1);
  endtask

  task automatic test_config_errors();
    apply_coreset(0, 3, 2, 0, 810, 1);    // identity needs bundles of six
    request_cce(8'd0);
    apply_coreset(1, 4, 2, 0, 816, 1);    // illegal bundle size
    request_cce(8'd0);
    apply_coreset(1, 2, 7, 0, 812, 1);    // illegal row count
    request_cce(8'd0);
    apply_coreset(1, 2, 2, 0, 810, 3);    // 810 not a multiple of L*R
    request_cce(8'd0);
    apply_coreset(0, 6, 2, 0, 810, 0);    // zero symbols
    request_cce(8'd0);
    apply_coreset(0, 6, 2, 0, 811, 1);    // set too large
    request_cce(8'd0);
    apply_coreset(1, 7, 7, 511, 1023, 3);
    request_cce(8'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned max_cce;
    bit calm;
    for (int phase = 0; phase < 10; phase++) begin
      calm = phase >= 8 || phase == 4;
      roll_coreset($urandom_range(0, 4) != 0);
      max_cce = (coreset.reg_count >= 6) ? coreset.reg_count / 6 - 1 : 0;
      for (int i = 0; i < 13; i++) begin
        if ($urandom_range(0, 6) != 0)
          request_cce(8'($urandom_range(0, max_cce)));
        else
          request_cce(8'($urandom_range(0, 255)));
        if (!calm && $urandom_range(0, 3) == 0)
          pause_requests($urandom_range(1, 16));
      end
    end
  endtask

  task automatic note_mismatch(input string what, input reg_result_t want, got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display({"%s: exp reg %0d sym %0d rb %0d err %b last %b,",
                " got reg %0d sym %0d rb %0d err %b last %b"},
               what, want.reg_index, want.symbol_index, want.rb_index, want.config_error,
               want.last_reg, got.reg_index, got.symbol_index, got.rb_index,
               got.config_error, got.last_reg);
  endtask

  always @(posedge clk_i) begin
    reg_result_t want, got;
    if (rst_ni && result_strobe_o === 1'b1) begin
      got = '{reg_index_o, symbol_index_o, rb_index_o, config_error_o, last_reg_o};
      if (expected_regs.size() == 0) begin
        note_mismatch("unexpected REG", '0, got);
      end else begin
        want = expected_regs.pop_front();
        if (got.reg_index !== want.reg_index || got.symbol_index !== want.symbol_index ||
            got.rb_index !== want.rb_index || got.config_error !== want.config_error ||
            got.last_reg !== want.last_reg)
          note_mismatch("REG mismatch", want, got);
      end
    end
  end

  // no request, result or register write for too long
  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || result_strobe_o === 1'b1 ||
        (cfg_valid_i && cfg_ready_o === 1'b1))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL cce_to_reg_interleave_map_top");
      $finish;
    end
  end

  initial begin
    coreset = '{1'b0, 3'd6, 3'd2, 9'd0, 10'd6, 2'd1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_identity_map();
    test_interleaved_map();
    test_config_errors();
    test_random_traffic();
    start_i <= 1'b0;
    while (expected_regs.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && expected_regs.size() == 0)
      $display("PASS cce_to_reg_interleave_map_top");
    else
      $display("FAIL cce_to_reg_interleave_map_top");
    $finish;
  end

endmodule

`default_nettype wire
